>>> sv/tajc_pkg.sv
// Two-axis jog controller: shared types, codes and reset constants.
// No dependencies; imported by tajc_step, two_axis_jog_controller and the testbench.
package tajc_pkg;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned TOUCH_W = 16;

    localparam logic [15:0] TOUCH_THRESHOLD_RST = 16'd50;
    localparam logic [15:0] BUTTON_MOVE_RST = 16'd10;
    localparam logic [15:0] BUTTON_TURN_RST = 16'd10;

    typedef enum logic [1:0] {
        CFG_TOUCH_THRESHOLD = 2'd0,
        CFG_BUTTON_MOVE     = 2'd1,
        CFG_BUTTON_TURN     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_LEFT      = 3'd1,
        CMD_RIGHT     = 3'd2,
        CMD_CW        = 3'd3,
        CMD_CCW       = 3'd4,
        CMD_STOP_MOVE = 3'd5,
        CMD_STOP_TURN = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        LIN_UNDEF = 3'd0,
        LIN_LEFT  = 3'd1,
        LIN_RIGHT = 3'd2,
        LIN_STOP  = 3'd3,
        LIN_MAXL  = 3'd4,
        LIN_MAXR  = 3'd5
    } t_lin;

    typedef enum logic [1:0] {
        ROT_UNDEF = 2'd0,
        ROT_CW    = 2'd1,
        ROT_CCW   = 2'd2,
        ROT_STOP  = 2'd3
    } t_rot;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef struct packed {
        logic [15:0] touch_threshold;
        logic [15:0] button_move_ticks;
        logic [15:0] button_turn_ticks;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic               left_limit;
        logic               right_limit;
        logic [TOUCH_W-1:0] touch_left;
        logic [TOUCH_W-1:0] touch_right;
        logic [TOUCH_W-1:0] touch_cw;
        logic [TOUCH_W-1:0] touch_ccw;
        logic               cmd_valid;
        logic [2:0]         cmd_kind;
        logic [CNT_W-1:0]   cmd_duration;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] move_ticks;
        logic [CNT_W-1:0] turn_ticks;
        logic             move_running;
        logic             move_dir;
        logic             turn_running;
        logic             turn_dir;
        t_lin             pub_lin;
        t_rot             pub_rot;
        logic             alarm;
    } t_state;

    typedef struct packed {
        logic move_run;
        logic move_dir;
        logic turn_run;
        logic turn_dir;
        logic alarm;
        t_lin linear_status;
        t_rot rotation_status;
        logic cmd_accepted;
    } t_result;

endpackage

>>> sv/tajc_step.sv
// Two-axis jog controller: next-state and result logic for one beat.
// Depends on tajc_pkg.
module tajc_step import tajc_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    logic pl, pr, pcw, pccw, lmax, rmax;
    logic accepted;
    t_lin lin;
    t_rot rot;
    t_state s;

    assign pl   = i_item.touch_left  < i_cfg.touch_threshold;
    assign pr   = i_item.touch_right < i_cfg.touch_threshold;
    assign pcw  = i_item.touch_cw    < i_cfg.touch_threshold;
    assign pccw = i_item.touch_ccw   < i_cfg.touch_threshold;
    assign lmax = i_item.left_limit;
    assign rmax = i_item.right_limit;

    always_comb begin
        s        = i_state;
        accepted = 1'b0;
        lin      = LIN_UNDEF;
        rot      = ROT_UNDEF;
        if (i_item.op == OP_TICK) begin
            if (s.move_ticks != '0) begin
                s.move_ticks = s.move_ticks - 1'b1;
                if (s.move_ticks == '0) s.move_running = 1'b0;
            end
            if (s.turn_ticks != '0) begin
                s.turn_ticks = s.turn_ticks - 1'b1;
                if (s.turn_ticks == '0) s.turn_running = 1'b0;
            end
        end else begin
            // end stop cancels timed movement only
            if (s.move_ticks != '0 && (lmax || rmax)) begin
                s.move_ticks   = '0;
                s.move_running = 1'b0;
            end
            s.alarm = (lmax && rmax) || (pl && pr) || (pcw && pccw);
            if (!s.alarm) begin
                if (!lmax) begin
                    if (pl) begin
                        lin          = LIN_LEFT;
                        s.move_ticks = i_cfg.button_move_ticks;
                    end
                end else if (!pr) begin
                    lin = LIN_MAXL;
                end
                if (!rmax) begin
                    if (pr) begin
                        lin          = LIN_RIGHT;
                        s.move_ticks = i_cfg.button_move_ticks;
                    end
                end else if (!pl) begin
                    lin = LIN_MAXR;
                end
                if (pcw) begin
                    rot          = ROT_CW;
                    s.turn_ticks = i_cfg.button_turn_ticks;
                end else if (pccw) begin
                    rot          = ROT_CCW;
                    s.turn_ticks = i_cfg.button_turn_ticks;
                end
                if (i_item.cmd_valid) begin
                    accepted = 1'b1;
                    case (i_item.cmd_kind)
                        CMD_LEFT: begin
                            if (!lmax) begin
                                lin          = LIN_LEFT;
                                s.move_ticks = i_item.cmd_duration;
                            end
                        end
                        CMD_RIGHT: begin
                            if (!rmax) begin
                                lin          = LIN_RIGHT;
                                s.move_ticks = i_item.cmd_duration;
                            end
                        end
                        CMD_CW: begin
                            rot          = ROT_CW;
                            s.turn_ticks = i_item.cmd_duration;
                        end
                        CMD_CCW: begin
                            rot          = ROT_CCW;
                            s.turn_ticks = i_item.cmd_duration;
                        end
                        CMD_STOP_MOVE: begin
                            lin          = LIN_STOP;
                            s.move_ticks = '0;
                        end
                        CMD_STOP_TURN: begin
                            rot          = ROT_STOP;
                            s.turn_ticks = '0;
                        end
                        default: ;
                    endcase
                end
                case (lin)
                    LIN_LEFT: begin
                        s.move_dir     = 1'b1;
                        s.move_running = 1'b1;
                    end
                    LIN_RIGHT: begin
                        s.move_dir     = 1'b0;
                        s.move_running = 1'b1;
                    end
                    LIN_STOP: s.move_running = 1'b0;
                    default: ;
                endcase
                case (rot)
                    ROT_CW: begin
                        s.turn_dir     = 1'b1;
                        s.turn_running = 1'b1;
                    end
                    ROT_CCW: begin
                        s.turn_dir     = 1'b0;
                        s.turn_running = 1'b1;
                    end
                    ROT_STOP: s.turn_running = 1'b0;
                    default: ;
                endcase
                s.pub_lin = lin;
                s.pub_rot = rot;
            end
        end
    end

    assign o_state = s;

    always_comb begin
        o_result.move_run        = s.move_running;
        o_result.move_dir        = s.move_dir;
        o_result.turn_run        = s.turn_running;
        o_result.turn_dir        = s.turn_dir;
        o_result.alarm           = s.alarm;
        o_result.linear_status   = s.pub_lin;
        o_result.rotation_status = s.pub_rot;
        o_result.cmd_accepted    = accepted;
    end

endmodule

>>> sv/two_axis_jog_controller.sv
// Two-axis jog controller top level: input register, state, result register.
// Depends on tajc_pkg and tajc_step.
//
// Input channel: i_valid / o_stall with one port per field. A beat is either
// a timer tick (i_op 0, only the op bit is used) or a sample of end stops,
// touch pads and an optional remote command (i_op 1).
// Output channel: o_valid / i_stall, one result beat per input beat, in order.
// Path: a beat taken in waits in the input register, then moves on to the result
// register, from which its result is offered.
// Throughput: one beat per cycle while the receiver does not stall; the controller
// state updates as a beat leaves the input register, so beats follow back to back.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, then o_stall rises until the result drains.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data, written while idle.
// Reset (synchronous, i_rst_n low) empties both registers, clears all motor
// state and status, and restores threshold 50 and button durations of 10.
module two_axis_jog_controller import tajc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic        i_left_limit,
    input  logic        i_right_limit,
    input  logic [15:0] i_touch_left,
    input  logic [15:0] i_touch_right,
    input  logic [15:0] i_touch_cw,
    input  logic [15:0] i_touch_ccw,
    input  logic        i_cmd_valid,
    input  logic [2:0]  i_cmd_kind,
    input  logic [15:0] i_cmd_duration,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_move_run,
    output logic        o_move_dir,
    output logic        o_turn_run,
    output logic        o_turn_dir,
    output logic        o_alarm,
    output logic [2:0]  o_linear_status,
    output logic [1:0]  o_rotation_status,
    output logic        o_cmd_accepted
);

    t_cfg    r_cfg;
    t_state  r_state, n_state;
    t_item   r_item;
    t_result r_result, n_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;
    logic    take;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.touch_threshold   <= TOUCH_THRESHOLD_RST;
            r_cfg.button_move_ticks <= BUTTON_MOVE_RST;
            r_cfg.button_turn_ticks <= BUTTON_TURN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOUCH_THRESHOLD: r_cfg.touch_threshold   <= i_cfg_data;
                CFG_BUTTON_MOVE:     r_cfg.button_move_ticks <= i_cfg_data;
                CFG_BUTTON_TURN:     r_cfg.button_turn_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.op           <= i_op;
            r_item.left_limit   <= i_left_limit;
            r_item.right_limit  <= i_right_limit;
            r_item.touch_left   <= i_touch_left;
            r_item.touch_right  <= i_touch_right;
            r_item.touch_cw     <= i_touch_cw;
            r_item.touch_ccw    <= i_touch_ccw;
            r_item.cmd_valid    <= i_cmd_valid;
            r_item.cmd_kind     <= i_cmd_kind;
            r_item.cmd_duration <= i_cmd_duration;
        end
    end

    tajc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_move_run        = r_result.move_run;
    assign o_move_dir        = r_result.move_dir;
    assign o_turn_run        = r_result.turn_run;
    assign o_turn_dir        = r_result.turn_dir;
    assign o_alarm           = r_result.alarm;
    assign o_linear_status   = r_result.linear_status;
    assign o_rotation_status = r_result.rotation_status;
    assign o_cmd_accepted    = r_result.cmd_accepted;

endmodule

>>> sim/tb_two_axis_jog_controller.sv
// Self-checking testbench for two_axis_jog_controller: directed and random beats,
// random idling on both channels, a long receiver hold-off and several register settings.
// Depends on tajc_pkg and the controller RTL; holds its own prediction of every result.
module tb_two_axis_jog_controller import tajc_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [2:0] CMD_UNDEFINED = 3'd7;
    localparam logic [15:0] PAD_DOWN = 16'd0;
    localparam logic [15:0] PAD_UP = 16'hFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_TOUCH_THRESHOLD;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    t_item       beat_in = '0;

    logic        o_stall, o_valid;
    logic        o_move_run, o_move_dir, o_turn_run, o_turn_dir, o_alarm, o_cmd_accepted;
    logic [2:0]  o_linear_status;
    logic [1:0]  o_rotation_status;

    two_axis_jog_controller u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (beat_in.op),
        .i_left_limit      (beat_in.left_limit),
        .i_right_limit     (beat_in.right_limit),
        .i_touch_left      (beat_in.touch_left),
        .i_touch_right     (beat_in.touch_right),
        .i_touch_cw        (beat_in.touch_cw),
        .i_touch_ccw       (beat_in.touch_ccw),
        .i_cmd_valid       (beat_in.cmd_valid),
        .i_cmd_kind        (beat_in.cmd_kind),
        .i_cmd_duration    (beat_in.cmd_duration),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_move_run        (o_move_run),
        .o_move_dir        (o_move_dir),
        .o_turn_run        (o_turn_run),
        .o_turn_dir        (o_turn_dir),
        .o_alarm           (o_alarm),
        .o_linear_status   (o_linear_status),
        .o_rotation_status (o_rotation_status),
        .o_cmd_accepted    (o_cmd_accepted)
    );

    // predicted controller state and register copies
    logic [15:0] thr_cfg = TOUCH_THRESHOLD_RST;
    logic [15:0] move_btn_cfg = BUTTON_MOVE_RST;
    logic [15:0] turn_btn_cfg = BUTTON_TURN_RST;
    logic [15:0] move_cnt = '0;
    logic [15:0] turn_cnt = '0;
    logic        mv_run = 1'b0, mv_dir = 1'b0, tn_run = 1'b0, tn_dir = 1'b0, lamp = 1'b0;
    t_lin        lin_pub = LIN_UNDEF;
    t_rot        rot_pub = ROT_UNDEF;

    t_result     jog_outputs_due[$];
    t_result     want;
    int          n_fail = 0, n_results = 0, n_alarms = 0, n_ticks = 0, n_samples = 0;
    int          cycle_cnt = 0;
    int          send_gap_max = 8, recv_gap_max = 8, hold_off = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     jog_outputs_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic advance_jog_state(input t_item it, output t_result r);
        logic lmax, rmax, pl, pr, pcw, pccw, acc;
        t_lin lin;
        t_rot rot;
        acc = 1'b0;
        if (it.op == OP_TICK) begin
            if (move_cnt != 0) begin
                move_cnt = move_cnt - 1'b1;
                if (move_cnt == 0) mv_run = 1'b0;
            end
            if (turn_cnt != 0) begin
                turn_cnt = turn_cnt - 1'b1;
                if (turn_cnt == 0) tn_run = 1'b0;
            end
        end else begin
            lmax = it.left_limit;
            rmax = it.right_limit;
            pl = it.touch_left < thr_cfg;
            pr = it.touch_right < thr_cfg;
            pcw = it.touch_cw < thr_cfg;
            pccw = it.touch_ccw < thr_cfg;
            // end stop cuts a timed linear run only
            if (move_cnt != 0 && (lmax || rmax)) begin
                move_cnt = '0;
                mv_run = 1'b0;
            end
            lamp = (lmax && rmax) || (pl && pr) || (pcw && pccw);
            if (!lamp) begin
                lin = LIN_UNDEF;
                rot = ROT_UNDEF;
                if (!lmax) begin
                    if (pl) begin
                        lin = LIN_LEFT;
                        move_cnt = move_btn_cfg;
                    end
                end else if (!pr) begin
                    lin = LIN_MAXL;
                end
                if (!rmax) begin
                    if (pr) begin
                        lin = LIN_RIGHT;
                        move_cnt = move_btn_cfg;
                    end
                end else if (!pl) begin
                    lin = LIN_MAXR;
                end
                if (pcw) begin
                    rot = ROT_CW;
                    turn_cnt = turn_btn_cfg;
                end else if (pccw) begin
                    rot = ROT_CCW;
                    turn_cnt = turn_btn_cfg;
                end
                if (it.cmd_valid) begin
                    case (it.cmd_kind)
                        CMD_LEFT: begin
                            if (!lmax) begin
                                lin = LIN_LEFT;
                                move_cnt = it.cmd_duration;
                            end
                        end
                        CMD_RIGHT: begin
                            if (!rmax) begin
                                lin = LIN_RIGHT;
                                move_cnt = it.cmd_duration;
                            end
                        end
                        CMD_CW: begin
                            rot = ROT_CW;
                            turn_cnt = it.cmd_duration;
                        end
                        CMD_CCW: begin
                            rot = ROT_CCW;
                            turn_cnt = it.cmd_duration;
                        end
                        CMD_STOP_MOVE: begin
                            lin = LIN_STOP;
                            move_cnt = '0;
                        end
                        CMD_STOP_TURN: begin
                            rot = ROT_STOP;
                            turn_cnt = '0;
                        end
                        default: ;
                    endcase
                end
                if (lin == LIN_LEFT) begin
                    mv_dir = 1'b1;
                    mv_run = 1'b1;
                end else if (lin == LIN_RIGHT) begin
                    mv_dir = 1'b0;
                    mv_run = 1'b1;
                end else if (lin == LIN_STOP) begin
                    mv_run = 1'b0;
                end
                if (rot == ROT_CW) begin
                    tn_dir = 1'b1;
                    tn_run = 1'b1;
                end else if (rot == ROT_CCW) begin
                    tn_dir = 1'b0;
                    tn_run = 1'b1;
                end else if (rot == ROT_STOP) begin
                    tn_run = 1'b0;
                end
                lin_pub = lin;
                rot_pub = rot;
                acc = it.cmd_valid;
            end
        end
        r.move_run = mv_run;
        r.move_dir = mv_dir;
        r.turn_run = tn_run;
        r.turn_dir = tn_dir;
        r.alarm = lamp;
        r.linear_status = lin_pub;
        r.rotation_status = rot_pub;
        r.cmd_accepted = acc;
    endtask

    function automatic int field_mismatch(string name, int unsigned exp, int unsigned act);
        if (exp == act) return 0;
        $display("%0t: %s expected %0d actual %0d", $time, name, exp, act);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (jog_outputs_due.size() == 0) begin
                $display("%0t: result beat with no expectation waiting", $time);
                n_fail++;
            end else begin
                want = jog_outputs_due.pop_front();
                n_results++;
                if (o_alarm) n_alarms++;
                n_fail += field_mismatch("move_run", 32'(want.move_run), 32'(o_move_run));
                n_fail += field_mismatch("move_dir", 32'(want.move_dir), 32'(o_move_dir));
                n_fail += field_mismatch("turn_run", 32'(want.turn_run), 32'(o_turn_run));
                n_fail += field_mismatch("turn_dir", 32'(want.turn_dir), 32'(o_turn_dir));
                n_fail += field_mismatch("alarm", 32'(want.alarm), 32'(o_alarm));
                n_fail += field_mismatch("linear_status", 32'(want.linear_status),
                                         32'(o_linear_status));
                n_fail += field_mismatch("rotation_status", 32'(want.rotation_status),
                                         32'(o_rotation_status));
                n_fail += field_mismatch("cmd_accepted", 32'(want.cmd_accepted),
                                         32'(o_cmd_accepted));
            end
        end
    end

    // result side: random stall per beat, or one long hold-off on request
    initial begin : result_sink
        int n;
        forever begin
            if (hold_off > 0) begin
                n = hold_off;
                hold_off = 0;
            end else begin
                n = $urandom_range(0, recv_gap_max);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_beat(input t_item it);
        int gap;
        t_result r;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat_in <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        advance_jog_state(it, r);
        jog_outputs_due.push_back(r);
        if (it.op == OP_TICK) n_ticks++;
        else n_samples++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (jog_outputs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TOUCH_THRESHOLD: thr_cfg = data;
            CFG_BUTTON_MOVE:     move_btn_cfg = data;
            CFG_BUTTON_TURN:     turn_btn_cfg = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [15:0] mv,
                              input logic [15:0] tn);
        settle();
        write_reg(CFG_TOUCH_THRESHOLD, thr);
        write_reg(CFG_BUTTON_MOVE, mv);
        write_reg(CFG_BUTTON_TURN, tn);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_item smp(input logic l, input logic r, input logic [15:0] tl,
                                  input logic [15:0] tr, input logic [15:0] tcw,
                                  input logic [15:0] tccw, input logic cv,
                                  input logic [2:0] kind, input logic [15:0] dur);
        t_item it;
        it.op = OP_SAMPLE;
        it.left_limit = l;
        it.right_limit = r;
        it.touch_left = tl;
        it.touch_right = tr;
        it.touch_cw = tcw;
        it.touch_ccw = tccw;
        it.cmd_valid = cv;
        it.cmd_kind = kind;
        it.cmd_duration = dur;
        return it;
    endfunction

    function automatic t_item tick_beat();
        t_item it;
        it = '0;
        it.op = OP_TICK;
        return it;
    endfunction

    function automatic logic [15:0] touch_value(input logic pressed);
        if (pressed && thr_cfg != 0) return 16'($urandom_range(0, thr_cfg - 1));
        if (!pressed) return 16'($urandom_range(thr_cfg, 65535));
        return 16'($urandom_range(0, 65535));
    endfunction

    // mostly clean samples; end stops, pad conflicts and odd commands now and then
    function automatic t_item random_beat(input int tick_pct);
        t_item it;
        int r;
        it.op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SAMPLE;
        r = $urandom_range(0, 15);
        it.left_limit = (r == 11 || r == 12 || r == 15);
        it.right_limit = (r >= 13);
        r = $urandom_range(0, 15);
        it.touch_left = touch_value((r >= 9 && r <= 11) || r == 15);
        it.touch_right = touch_value(r >= 12);
        r = $urandom_range(0, 15);
        it.touch_cw = touch_value((r >= 9 && r <= 11) || r == 15);
        it.touch_ccw = touch_value(r >= 12);
        if ($urandom_range(0, 7) == 0) begin
            it.touch_left = 16'($urandom_range(0, 65535));
            it.touch_right = 16'($urandom_range(0, 65535));
            it.touch_cw = 16'($urandom_range(0, 65535));
            it.touch_ccw = 16'($urandom_range(0, 65535));
        end
        it.cmd_valid = ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 9) < 9) it.cmd_kind = 3'($urandom_range(CMD_LEFT, CMD_STOP_TURN));
        else it.cmd_kind = $urandom_range(0, 1) ? CMD_UNDEFINED : CMD_NONE;
        r = $urandom_range(0, 9);
        if (r < 2) it.cmd_duration = 16'd0;
        else if (r < 8) it.cmd_duration = 16'($urandom_range(1, 12));
        else if (r == 8) it.cmd_duration = 16'($urandom_range(0, 65535));
        else it.cmd_duration = 16'hFFFF;
        return it;
    endfunction

    task automatic test_directed();
        send_beat(tick_beat());
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 0, CMD_NONE, 0));
        send_beat(smp(0, 0, PAD_DOWN, PAD_UP, PAD_UP, PAD_UP, 0, CMD_NONE, 0));
        send_beat(tick_beat());
        send_beat(smp(0, 0, PAD_UP, 16'd49, PAD_UP, PAD_UP, 0, CMD_NONE, 0));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_DOWN, 16'd50, 0, CMD_NONE, 0));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, 16'd50, PAD_DOWN, 0, CMD_NONE, 0));
        // conflicts: both move pads, both end stops, both turn pads
        send_beat(smp(0, 0, PAD_DOWN, PAD_DOWN, PAD_UP, PAD_UP, 0, CMD_NONE, 0));
        send_beat(tick_beat());
        send_beat(smp(1, 1, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_LEFT, 5));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_DOWN, PAD_DOWN, 1, CMD_CW, 5));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_LEFT, 2));
        send_beat(tick_beat());
        send_beat(tick_beat());
        // untimed run survives an end stop; blocked directions
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_RIGHT, 0));
        send_beat(smp(1, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 0, CMD_NONE, 0));
        send_beat(smp(1, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_LEFT, 4));
        send_beat(smp(0, 1, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_RIGHT, 4));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_LEFT, 16'hFFFF));
        send_beat(smp(0, 1, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_CW, 3));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_NONE, 7));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_UNDEFINED, 7));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_STOP_MOVE, 0));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 1, CMD_STOP_TURN, 0));
        send_beat(smp(0, 0, PAD_UP, PAD_UP, PAD_UP, PAD_UP, 0, CMD_LEFT, 9));
        send_beat(smp(1, 0, PAD_UP, PAD_DOWN, PAD_UP, PAD_UP, 1, CMD_CCW, 16'hFFFF));
    endtask

    task automatic test_register_extremes();
        set_config(16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 60; k++) send_beat(random_beat(45));
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 60; k++) send_beat(random_beat(45));
    endtask

    task automatic test_random_settings();
        logic [15:0] thr;
        for (int p = 0; p < 6; p++) begin
            thr = (p == 0) ? 16'd1 : (p == 1) ? 16'd300 : 16'($urandom_range(2, 65534));
            set_config(thr, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
            send_gap_max = (p == 3) ? 0 : 8;
            recv_gap_max = (p == 4) ? 0 : 8;
            for (int k = 0; k < 180; k++) send_beat(random_beat(45));
        end
        send_gap_max = 8;
        recv_gap_max = 8;
    endtask

    task automatic test_backpressure();
        set_config(TOUCH_THRESHOLD_RST, 16'd5, 16'd5);
        send_gap_max = 0;
        hold_off = 300;
        for (int k = 0; k < 40; k++) send_beat(random_beat(45));
        send_gap_max = 8;
    endtask

    task automatic test_back_to_back();
        set_config(16'd120, 16'd3, 16'd7);
        send_gap_max = 0;
        recv_gap_max = 0;
        for (int k = 0; k < 150; k++) send_beat(random_beat(50));
        send_gap_max = 8;
        recv_gap_max = 8;
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        test_back_to_back();
        settle();
        n_fail += jog_outputs_due.size();
        $display("Sent %0d beats (%0d samples, %0d ticks) over eleven register settings;",
                 n_samples + n_ticks, n_samples, n_ticks);
        $display("checked %0d results, %0d with the alarm lamp on.", n_results, n_alarms);
        if (n_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
